@@ hdl/las_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and count coding for the locus annotation store.
package las_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_Q_INFO,
        ST_Q_WAIT,
        ST_Q_SCAN,
        ST_Q_DONE
    } t_state;

    localparam logic       CMD_PUSH   = 1'b0;
    localparam logic       CMD_QUERY  = 1'b1;
    localparam logic       REG_KMER   = 1'b0;
    localparam logic       REG_LOCI   = 1'b1;
    localparam logic       STATUS_OK  = 1'b0;
    localparam logic       STATUS_OOR = 1'b1;
    localparam logic [15:0] NO_INFO   = 16'hFFFF;
    localparam logic [7:0] MM_OVERFLOW = 8'd255;
    localparam logic [7:0] MARK_BIT   = 8'h80;
    localparam logic [7:0] ALIGN_BIT  = 8'h40;
    localparam int         SCAN_CAP   = 64;
    localparam int         MM_FIELDS  = 3;

    function automatic logic [3:0] count_code(input logic [15:0] c);
        logic [3:0] code;
        if (c <= 16'd10)       code = c[3:0];
        else if (c <= 16'd20)  code = 4'hB;
        else if (c <= 16'd50)  code = 4'hC;
        else if (c <= 16'd100) code = 4'hD;
        else if (c <= 16'd500) code = 4'hE;
        else                   code = 4'hF;
        return code;
    endfunction

    function automatic logic [9:0] count_decode(input logic [3:0] code);
        logic [9:0] v;
        case (code)
            4'hB:    v = 10'd15;
            4'hC:    v = 10'd40;
            4'hD:    v = 10'd75;
            4'hE:    v = 10'd300;
            4'hF:    v = 10'd1000;
            default: v = {6'd0, code};
        endcase
        return v;
    endfunction

endpackage

@@ hdl/las_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port byte memory, one write and one registered read port.
module las_ram #(
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/locus_annotation_store.sv @@
`timescale 1ns / 1ps
// Top level of the locus annotation store: command sequencer around the byte memory.
//
// Channels: an input channel (i_in_valid / o_in_ready) takes push and query
// commands; an output channel (o_out_valid / i_out_ready) returns query results;
// a configuration channel (i_cfg_valid / o_cfg_ready) writes k-mer length
// (index 0) and loci in use (index 1), and is always ready.
// Commands are handled one at a time from a single memory with registered reads.
// A push reads and writes back each touched byte, steps past each unused
// mismatch slot and returns to idle. A query reads the info byte, then scans
// the clipped k-mer window (empty when the alignment flag is clear), one store
// byte read per cycle; a hit that finds the output register still full drops
// the read and fetches the byte again. Out-of-range queries skip the store and
// go straight to the result.
// Results leave through an output register, so the next command is taken
// while the last result still waits. A stalled receiver holds the scan.
// After reset the block clears all LOCI bytes of the store, one byte per cycle;
// o_in_ready stays low meanwhile, configuration writes are taken as ever.
module locus_annotation_store
    import las_pkg::*;
#(
    parameter int LOCI        = 65536,
    parameter int ALIGN_SLOTS = 3,
    parameter int MAX_KMER    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [16:0] i_position,
    input  logic [15:0] i_neighbor_count,
    input  logic [7:0]  i_distance,
    input  logic [7:0]  i_mismatch_first,
    input  logic [7:0]  i_mismatch_second,
    input  logic [7:0]  i_mismatch_third,
    input  logic        i_reverse_strand,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [9:0]  o_decoded_count,
    output logic [2:0]  o_closest_distance,
    output logic        o_on_reverse,
    output logic [5:0]  o_align_offset,
    output logic        o_align_valid,
    output logic        o_last
);

    localparam int AW    = $clog2(LOCI);
    localparam int SW    = ($clog2(LOCI + 1) > 17) ? $clog2(LOCI + 1) : 17;
    localparam int SLOTS = (ALIGN_SLOTS < MM_FIELDS) ? ALIGN_SLOTS : MM_FIELDS;
    localparam int KCAP  = (MAX_KMER < SCAN_CAP) ? MAX_KMER : SCAN_CAP;

    // control
    t_state      r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [6:0]  r_kmer;
    logic [16:0] r_loci;
    logic [1:0]  r_slot, n_slot;
    logic [3:0]  r_en, n_en;
    logic [6:0]  r_idx, n_idx;
    logic        r_inflight, n_inflight;
    logic        r_pend_valid, n_pend_valid;
    logic        r_out_valid, n_out_valid;
    // payload
    logic [AW-1:0] r_addr [4];
    logic [AW-1:0] n_addr [4];
    logic [7:0]  r_byte, n_byte;
    logic [AW-1:0] r_qpos, n_qpos;
    logic        r_rev, n_rev;
    logic        r_oor, n_oor;
    logic [9:0]  r_cnt, n_cnt;
    logic [2:0]  r_dist, n_dist;
    logic [6:0]  r_end, n_end;
    logic [6:0]  r_chk_idx, n_chk_idx;
    logic [5:0]  r_pend_off, n_pend_off;
    logic        r_o_status, n_o_status;
    logic [9:0]  r_o_count, n_o_count;
    logic [2:0]  r_o_dist, n_o_dist;
    logic        r_o_rev, n_o_rev;
    logic [5:0]  r_o_off, n_o_off;
    logic        r_o_av, n_o_av;
    logic        r_o_last, n_o_last;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [SW:0] loci_ext;
    logic [SW:0] s_size;
    logic [6:0]  k_eff;
    logic        out_free;

    las_ram #(.DEPTH(LOCI)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign loci_ext = (SW + 1)'(r_loci);
    assign s_size   = (loci_ext < (SW + 1)'(LOCI)) ? loci_ext : (SW + 1)'(LOCI);
    assign k_eff    = (r_kmer > 7'(KCAP)) ? 7'(KCAP) : r_kmer;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer <= 7'd2;
            r_loci <= 17'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KMER: r_kmer <= i_cfg_data[6:0];
                REG_LOCI: r_loci <= i_cfg_data;
                default:  r_loci <= r_loci;
            endcase
        end
    end

    always_comb begin
        logic [SW:0] pos_ext;
        logic [SW:0] t_ext;
        logic [SW:0] remaining;
        logic [7:0]  mm [MM_FIELDS];
        logic [7:0]  am;
        logic        alive;
        logic        push_ok;
        logic        hit;
        logic        absorb;
        logic [5:0]  off;
        logic [3:0]  code;
        logic [AW:0] idx_sum;

        n_state      = r_state;
        n_clr        = r_clr;
        n_slot       = r_slot;
        n_en         = r_en;
        n_idx        = r_idx;
        n_inflight   = r_inflight;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_addr       = r_addr;
        n_byte       = r_byte;
        n_qpos       = r_qpos;
        n_rev        = r_rev;
        n_oor        = r_oor;
        n_cnt        = r_cnt;
        n_dist       = r_dist;
        n_end        = r_end;
        n_chk_idx    = r_chk_idx;
        n_pend_off   = r_pend_off;
        n_o_status   = r_o_status;
        n_o_count    = r_o_count;
        n_o_dist     = r_o_dist;
        n_o_rev      = r_o_rev;
        n_o_off      = r_o_off;
        n_o_av       = r_o_av;
        n_o_last     = r_o_last;

        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = 8'd0;
        ram_re    = 1'b0;
        ram_raddr = r_qpos;

        pos_ext   = (SW + 1)'(i_position);
        mm[0]     = i_mismatch_first;
        mm[1]     = i_mismatch_second;
        mm[2]     = i_mismatch_third;
        am        = 8'd0;
        t_ext     = '0;
        alive     = 1'b0;
        push_ok   = 1'b0;
        hit       = r_inflight && ram_rdata[7];
        absorb    = 1'b1;
        off       = r_rev ? 6'(k_eff - 7'd1 - r_chk_idx) : r_chk_idx[5:0];
        code      = ram_rdata[3:0];
        remaining = s_size - (SW + 1)'(r_qpos);
        idx_sum   = (AW + 1)'(r_qpos) + (AW + 1)'(r_idx);

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(LOCI - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_PUSH) begin
                        push_ok = (pos_ext < s_size) && (i_neighbor_count != 16'd0)
                                  && (i_neighbor_count != NO_INFO);
                        n_byte = {1'b0, (i_mismatch_first != MM_OVERFLOW),
                                  2'(i_distance - 8'd1), count_code(i_neighbor_count)};
                        n_addr[0] = pos_ext[AW-1:0];
                        n_en      = {3'b000, push_ok};
                        alive     = push_ok && (i_mismatch_first != MM_OVERFLOW);
                        for (int j = 0; j < MM_FIELDS; j++) begin
                            n_addr[j+1] = r_addr[j+1];
                            if (j < SLOTS && alive) begin
                                am = i_reverse_strand ? 8'({1'b0, r_kmer} + 8'd1 - mm[j])
                                                      : mm[j];
                                if (mm[j] == 8'd0 || am == 8'd0) begin
                                    alive = 1'b0;
                                end else begin
                                    t_ext = pos_ext + (SW + 1)'(am) - 1'b1;
                                    n_addr[j+1] = t_ext[AW-1:0];
                                    n_en[j+1]   = (t_ext < s_size);
                                end
                            end
                        end
                        n_slot  = 2'd0;
                        n_state = ST_PUSH_RD;
                    end else begin
                        n_oor = (pos_ext >= (s_size << 1));
                        n_rev = (pos_ext >= s_size);
                        if (pos_ext >= s_size) begin
                            t_ext = (s_size << 1) - 1'b1 - pos_ext;
                        end else begin
                            t_ext = pos_ext;
                        end
                        n_qpos = t_ext[AW-1:0];
                        n_state = (pos_ext >= (s_size << 1)) ? ST_Q_DONE : ST_Q_INFO;
                    end
                end
            end

            ST_PUSH_RD: begin
                ram_raddr = r_addr[r_slot];
                if (r_en[r_slot]) begin
                    ram_re  = 1'b1;
                    n_state = ST_PUSH_WR;
                end else begin
                    n_slot = r_slot + 1'b1;
                    if (r_slot == 2'd3) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_PUSH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[r_slot];
                ram_wdata = ram_rdata | ((r_slot == 2'd0) ? r_byte : MARK_BIT);
                n_slot    = r_slot + 1'b1;
                n_state   = (r_slot == 2'd3) ? ST_IDLE : ST_PUSH_RD;
            end

            ST_Q_INFO: begin
                ram_re    = 1'b1;
                ram_raddr = r_qpos;
                n_state   = ST_Q_WAIT;
            end

            ST_Q_WAIT: begin
                n_cnt  = count_decode(code);
                n_dist = (code != 4'd0) ? ({1'b0, ram_rdata[5:4]} + 3'd1) : 3'd0;
                if ((ram_rdata & ALIGN_BIT) != 8'd0) begin
                    n_end = (remaining < (SW + 1)'(k_eff)) ? remaining[6:0] : k_eff;
                end else begin
                    n_end = 7'd0;
                end
                n_idx        = 7'd0;
                n_inflight   = 1'b0;
                n_pend_valid = 1'b0;
                n_state      = ST_Q_SCAN;
            end

            ST_Q_SCAN: begin
                if (hit) begin
                    if (r_pend_valid) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_o_status  = STATUS_OK;
                            n_o_count   = r_cnt;
                            n_o_dist    = r_dist;
                            n_o_rev     = r_rev;
                            n_o_off     = r_pend_off;
                            n_o_av      = 1'b1;
                            n_o_last    = 1'b0;
                            n_pend_off  = off;
                        end else begin
                            absorb = 1'b0;
                        end
                    end else begin
                        n_pend_valid = 1'b1;
                        n_pend_off   = off;
                    end
                end
                if (!absorb) begin
                    // output full: drop the read and fetch this byte again
                    n_idx      = r_chk_idx;
                    n_inflight = 1'b0;
                end else if (r_idx < r_end) begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_sum[AW-1:0];
                    n_chk_idx  = r_idx;
                    n_idx      = r_idx + 1'b1;
                    n_inflight = 1'b1;
                end else begin
                    n_inflight = 1'b0;
                    n_state    = ST_Q_DONE;
                end
            end

            ST_Q_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_last    = 1'b1;
                    if (r_oor) begin
                        n_o_status = STATUS_OOR;
                        n_o_count  = 10'd0;
                        n_o_dist   = 3'd0;
                        n_o_rev    = 1'b0;
                        n_o_off    = 6'd0;
                        n_o_av     = 1'b0;
                    end else begin
                        n_o_status = STATUS_OK;
                        n_o_count  = r_cnt;
                        n_o_dist   = r_dist;
                        n_o_rev    = r_rev;
                        n_o_off    = r_pend_valid ? r_pend_off : 6'd0;
                        n_o_av     = r_pend_valid;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_slot       <= 2'd0;
            r_en         <= 4'd0;
            r_idx        <= 7'd0;
            r_inflight   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_slot       <= n_slot;
            r_en         <= n_en;
            r_idx        <= n_idx;
            r_inflight   <= n_inflight;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_byte     <= n_byte;
        r_qpos     <= n_qpos;
        r_rev      <= n_rev;
        r_oor      <= n_oor;
        r_cnt      <= n_cnt;
        r_dist     <= n_dist;
        r_end      <= n_end;
        r_chk_idx  <= n_chk_idx;
        r_pend_off <= n_pend_off;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_dist   <= n_o_dist;
        r_o_rev    <= n_o_rev;
        r_o_off    <= n_o_off;
        r_o_av     <= n_o_av;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_decoded_count    = r_o_count;
    assign o_closest_distance = r_o_dist;
    assign o_on_reverse       = r_o_rev;
    assign o_align_offset     = r_o_off;
    assign o_align_valid      = r_o_av;
    assign o_last             = r_o_last;

endmodule
